[hw/rtl/bfs_pkg.sv]
package bfs_pkg;

  localparam logic [23:0] GravityReset = 24'd642908;
  localparam logic [22:0] Deg90        = 23'd5898240;
  localparam logic signed [23:0] Deg90S = 24'sd5898240;
  localparam logic [21:0] Deg45        = 22'd2949120;
  localparam logic [24:0] Deg2RadQ30   = 25'd18740330;
  localparam logic [30:0] Q30One       = 31'd1073741824;

  localparam int TaylorTerms = 6;
  localparam int unsigned TaylorK [TaylorTerms] = '{156, 110, 72, 42, 20, 6};
  localparam int SinStages   = 3 + 3 * TaylorTerms;

  localparam int SqrtSteps   = 25;
  localparam int DivSteps    = 31;
  localparam int DivFrac     = 22;
  localparam int SearchSteps = 22;
  localparam int TofSteps    = 32;

  typedef struct packed {
    logic [23:0]        shooter_x;
    logic [23:0]        shooter_y;
    logic [23:0]        aim_x;
    logic [23:0]        aim_y;
    logic [23:0]        muzzle_speed;
    logic signed [23:0] angle_floor;
    logic signed [23:0] angle_ceiling;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [22:0] elevation;
    logic [31:0] time_of_flight;
  } rsp_t;

  typedef struct packed {
    logic        vld;
    logic        done;
    logic        hit;
    logic [22:0] ang;
    logic [22:0] win_lo;
    logic [22:0] win_hi;
    logic [23:0] v;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [21:0] lo;
    logic [21:0] hi;
    logic [21:0] mid;
    logic [30:0] q;
  } ctx_t;

endpackage

[hw/rtl/bfs_sin.sv]
module bfs_sin import bfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  ctx_t        ctx_i,
  input  logic [22:0] angle_i,
  output ctx_t        ctx_o,
  output logic [30:0] sin_o
);

  ctx_t ctx_q [SinStages];

  logic [30:0] x_w  [TaylorTerms+1];
  logic [31:0] x2_w [TaylorTerms+1];
  logic [30:0] t_w  [TaylorTerms+1];

  logic [30:0] x0_q, x1_q;
  logic [31:0] x2_1_q;
  logic [30:0] s_q;
  logic [47:0] prod0;
  logic [61:0] prod1;
  logic [61:0] prodf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < SinStages; n++) ctx_q[n] <= '0;
    end else if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int n = 1; n < SinStages; n++) ctx_q[n] <= ctx_q[n-1];
    end
  end

  assign prod0 = {25'b0, angle_i} * {23'b0, Deg2RadQ30};
  assign prod1 = {31'b0, x0_q} * {31'b0, x0_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= prod0[46:16];
      x1_q   <= x0_q;
      x2_1_q <= prod1[61:30];
    end
  end

  assign x_w[0]  = x1_q;
  assign x2_w[0] = x2_1_q;
  assign t_w[0]  = Q30One;

  for (genvar j = 0; j < TaylorTerms; j++) begin : g_term
    localparam logic [29:0] RecipM = 30'((64'd1 << 32) / 64'(TaylorK[j]));
    localparam logic [7:0]  DivK   = 8'(TaylorK[j]);

    logic [31:0] pa_q, pb_q;
    logic [30:0] xa_q, xb_q, xc_q;
    logic [31:0] x2a_q, x2b_q, x2c_q;
    logic [29:0] qeb_q;
    logic [30:0] tc_q;
    logic [62:0] mul_a;
    logic [61:0] mul_b;
    logic [37:0] mul_c;
    logic [31:0] rem_c;
    logic [29:0] qd_c;

    assign mul_a = {31'b0, x2_w[j]} * {32'b0, t_w[j]};
    assign mul_b = {30'b0, pa_q} * {32'b0, RecipM};
    assign mul_c = {8'b0, qeb_q} * {30'b0, DivK};
    assign rem_c = pb_q - mul_c[31:0];
    assign qd_c  = (rem_c >= {24'b0, DivK}) ? qeb_q + 30'd1 : qeb_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q  <= mul_a[61:30];
        xa_q  <= x_w[j];
        x2a_q <= x2_w[j];
        qeb_q <= mul_b[61:32];
        pb_q  <= pa_q;
        xb_q  <= xa_q;
        x2b_q <= x2a_q;
        tc_q  <= Q30One - {1'b0, qd_c};
        xc_q  <= xb_q;
        x2c_q <= x2b_q;
      end
    end

    assign x_w[j+1]  = xc_q;
    assign x2_w[j+1] = x2c_q;
    assign t_w[j+1]  = tc_q;
  end

  assign prodf = {31'b0, x_w[TaylorTerms]} * {31'b0, t_w[TaylorTerms]};

  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= prodf[60:30];
  end

  assign ctx_o = ctx_q[SinStages-1];
  assign sin_o = s_q;

endmodule

[hw/rtl/ballistic_firing_solution.sv]
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_data_i (gravity, Q8.16)
// request   in         in_valid_i / in_ready_o    in_data_i (req_t)
// result    out        out_valid_o / out_ready_i  out_data_o (rsp_t)
//
// One request enters per cycle while the result is not stalled; the search
// has 22 binary-search steps, each a 21-stage sine pipeline plus an update.
// The root, ratio divider and flight-time divider resolve one bit per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default gravity.
module ballistic_firing_solution import bfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  localparam logic [21:0] MidInit = (Deg45 + 22'd1) >> 1;

  logic        en;
  logic [23:0] gravity_q;
  logic [28:0] den2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gravity_q <= GravityReset;
    else if (cfg_valid_i) gravity_q <= cfg_data_i;
  end

  assign den2 = {gravity_q, 5'b0};

  // Front: distances and window checks
  tag_t        a_tag, a_tag_q, b_tag_q;
  logic [23:0] a_dx, a_dy, a_dx_q, a_dy_q;
  logic [47:0] b_sqx_q, b_sqy_q;
  logic [48:0] c_d2;
  tag_t        c_tag;

  always_comb begin
    a_dx = (in_data_i.aim_x >= in_data_i.shooter_x) ? in_data_i.aim_x - in_data_i.shooter_x
                                                     : in_data_i.shooter_x - in_data_i.aim_x;
    a_dy = (in_data_i.aim_y >= in_data_i.shooter_y) ? in_data_i.aim_y - in_data_i.shooter_y
                                                     : in_data_i.shooter_y - in_data_i.aim_y;
    a_tag        = '0;
    a_tag.vld    = in_valid_i;
    a_tag.done   = (in_data_i.muzzle_speed == 24'd0) || (gravity_q == 24'd0) ||
                   in_data_i.angle_floor[23] || (in_data_i.angle_ceiling > Deg90S) ||
                   (in_data_i.angle_floor > in_data_i.angle_ceiling);
    a_tag.win_lo = in_data_i.angle_floor[22:0];
    a_tag.win_hi = in_data_i.angle_ceiling[22:0];
    a_tag.v      = in_data_i.muzzle_speed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
    end else if (en) begin
      a_tag_q <= a_tag;
      b_tag_q <= a_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q  <= a_dx;
      a_dy_q  <= a_dy;
      b_sqx_q <= {24'b0, a_dx_q} * {24'b0, a_dx_q};
      b_sqy_q <= {24'b0, a_dy_q} * {24'b0, a_dy_q};
    end
  end

  always_comb begin
    c_d2  = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
    c_tag = b_tag_q;
    if (!b_tag_q.done && c_d2 == 49'd0) begin
      c_tag.done = 1'b1;
      c_tag.hit  = 1'b1;
      c_tag.ang  = b_tag_q.win_lo;
    end
  end

  // Square root, one result bit per stage
  tag_t        rt_tag_q  [SqrtSteps+1];
  logic [48:0] rt_d2_q   [SqrtSteps+1];
  logic [26:0] rt_rem_q  [SqrtSteps+1];
  logic [24:0] rt_root_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n <= SqrtSteps; n++) rt_tag_q[n] <= '0;
    end else if (en) begin
      rt_tag_q[0] <= c_tag;
      for (int n = 1; n <= SqrtSteps; n++) rt_tag_q[n] <= rt_tag_q[n-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_d2_q[0]   <= c_d2;
      rt_rem_q[0]  <= '0;
      rt_root_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    localparam int J = SqrtSteps - 1 - s;
    logic [49:0] pad;
    logic [28:0] r2;
    logic [28:0] trial;
    logic        ge;

    assign pad   = {1'b0, rt_d2_q[s]};
    assign r2    = {rt_rem_q[s], pad[2*J +: 2]};
    assign trial = {2'b0, rt_root_q[s], 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_d2_q[s+1]   <= rt_d2_q[s];
        rt_rem_q[s+1]  <= ge ? 27'(r2 - trial) : r2[26:0];
        rt_root_q[s+1] <= {rt_root_q[s][23:0], ge};
      end
    end
  end

  // Ratio d*g / v^2 and the range check
  tag_t        d_tag_q, e_tag;
  logic [48:0] d_num_q;
  logic [47:0] d_den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_num_q <= {24'b0, rt_root_q[SqrtSteps]} * {25'b0, gravity_q};
      d_den_q <= {24'b0, rt_tag_q[SqrtSteps].v} * {24'b0, rt_tag_q[SqrtSteps].v};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_tag_q <= '0;
    else if (en) d_tag_q <= rt_tag_q[SqrtSteps];
  end

  always_comb begin
    e_tag = d_tag_q;
    if (!d_tag_q.done && ({7'b0, d_num_q} > {d_den_q, 8'b0})) begin
      e_tag.done = 1'b1;
      e_tag.hit  = 1'b0;
    end
  end

  tag_t        dv_tag_q [DivSteps+1];
  logic [47:0] dv_rem_q [DivSteps+1];
  logic [8:0]  dv_nlo_q [DivSteps+1];
  logic [47:0] dv_den_q [DivSteps+1];
  logic [30:0] dv_quo_q [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n <= DivSteps; n++) dv_tag_q[n] <= '0;
    end else if (en) begin
      dv_tag_q[0] <= e_tag;
      for (int n = 1; n <= DivSteps; n++) dv_tag_q[n] <= dv_tag_q[n-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0] <= {8'b0, d_num_q[48:9]};
      dv_nlo_q[0] <= d_num_q[8:0];
      dv_den_q[0] <= d_den_q;
      dv_quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    localparam int I = DivSteps - 1 - s;
    logic        nbit;
    logic [48:0] r2;
    logic        ge;

    if (I >= DivFrac) begin : g_num
      assign nbit = dv_nlo_q[s][I-DivFrac];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign r2 = {dv_rem_q[s], nbit};
    assign ge = r2 >= {1'b0, dv_den_q[s]};

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[s+1] <= ge ? 48'(r2 - {1'b0, dv_den_q[s]}) : r2[47:0];
        dv_nlo_q[s+1] <= dv_nlo_q[s];
        dv_den_q[s+1] <= dv_den_q[s];
        dv_quo_q[s+1] <= {dv_quo_q[s][29:0], ge};
      end
    end
  end

  // Binary search for the low angle
  ctx_t        sr_q   [SearchSteps+1];
  ctx_t        sn_ctx [SearchSteps];
  logic [30:0] sn_sin [SearchSteps];
  ctx_t        sr_init;

  always_comb begin
    sr_init     = '0;
    sr_init.tag = dv_tag_q[DivSteps];
    sr_init.lo  = '0;
    sr_init.hi  = Deg45;
    sr_init.mid = MidInit;
    sr_init.q   = dv_quo_q[DivSteps];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sr_q[0] <= '0;
    else if (en) sr_q[0] <= sr_init;
  end

  for (genvar it = 0; it < SearchSteps; it++) begin : g_search
    ctx_t        nxt;
    logic [22:0] span;

    bfs_sin u_sin (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctx_i   (sr_q[it]),
      .angle_i ({sr_q[it].mid, 1'b0}),
      .ctx_o   (sn_ctx[it]),
      .sin_o   (sn_sin[it])
    );

    always_comb begin
      nxt = sn_ctx[it];
      if (sn_ctx[it].lo < sn_ctx[it].hi) begin
        if (sn_sin[it] <= sn_ctx[it].q) nxt.lo = sn_ctx[it].mid;
        else nxt.hi = sn_ctx[it].mid - 22'd1;
      end
      span    = {1'b0, nxt.hi} - {1'b0, nxt.lo} + 23'd1;
      nxt.mid = nxt.lo + span[22:1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_q[it+1] <= '0;
      else if (en) sr_q[it+1] <= nxt;
    end
  end

  // Pick the angle inside the window
  ctx_t        sel, sel_q;
  logic [22:0] low, high;

  always_comb begin
    low  = {1'b0, sr_q[SearchSteps].lo};
    high = Deg90 - low;
    sel  = sr_q[SearchSteps];
    if (!sel.tag.done) begin
      if (low >= sel.tag.win_lo && low <= sel.tag.win_hi) begin
        sel.tag.ang = low;
      end else if (high >= sel.tag.win_lo && high <= sel.tag.win_hi) begin
        sel.tag.ang = high;
      end else begin
        sel.tag.done = 1'b1;
        sel.tag.hit  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_q <= '0;
    else if (en) sel_q <= sel;
  end

  ctx_t        fn_ctx;
  logic [30:0] fn_sin;

  bfs_sin u_sin_tof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctx_i   (sel_q),
    .angle_i (sel_q.tag.ang),
    .ctx_o   (fn_ctx),
    .sin_o   (fn_sin)
  );

  // Flight time v*sin / (32*g), saturating
  tag_t        m_tag_q;
  logic [54:0] m_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_tag_q <= '0;
    else if (en) m_tag_q <= fn_ctx.tag;
  end

  always_ff @(posedge clk_i) begin
    if (en) m_num_q <= {31'b0, fn_ctx.tag.v} * {24'b0, fn_sin};
  end

  tag_t        tf_tag_q [TofSteps+1];
  logic [28:0] tf_rem_q [TofSteps+1];
  logic [31:0] tf_nlo_q [TofSteps+1];
  logic [31:0] tf_quo_q [TofSteps+1];
  logic        tf_sat_q [TofSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n <= TofSteps; n++) tf_tag_q[n] <= '0;
    end else if (en) begin
      tf_tag_q[0] <= m_tag_q;
      for (int n = 1; n <= TofSteps; n++) tf_tag_q[n] <= tf_tag_q[n-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tf_rem_q[0] <= {6'b0, m_num_q[54:32]};
      tf_nlo_q[0] <= m_num_q[31:0];
      tf_quo_q[0] <= '0;
      tf_sat_q[0] <= {6'b0, m_num_q[54:32]} >= den2;
    end
  end

  for (genvar s = 0; s < TofSteps; s++) begin : g_tof
    localparam int I = TofSteps - 1 - s;
    logic [29:0] r2;
    logic        ge;

    assign r2 = {tf_rem_q[s], tf_nlo_q[s][I]};
    assign ge = r2 >= {1'b0, den2};

    always_ff @(posedge clk_i) begin
      if (en) begin
        tf_rem_q[s+1] <= ge ? 29'(r2 - {1'b0, den2}) : r2[28:0];
        tf_nlo_q[s+1] <= tf_nlo_q[s];
        tf_quo_q[s+1] <= {tf_quo_q[s][30:0], ge};
        tf_sat_q[s+1] <= tf_sat_q[s];
      end
    end
  end

  // Result register
  tag_t ot;
  rsp_t rsp, out_q;
  logic out_vld_q;

  assign ot = tf_tag_q[TofSteps];

  always_comb begin
    rsp = '0;
    if (ot.done) begin
      rsp.hit       = ot.hit;
      rsp.elevation = ot.hit ? ot.ang : 23'd0;
    end else begin
      rsp.hit            = 1'b1;
      rsp.elevation      = ot.ang;
      rsp.time_of_flight = tf_sat_q[TofSteps] ? '1 : tf_quo_q[TofSteps];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= ot.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= rsp;
  end

  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
